FILE: hw/rtl/key_scan_to_midi_events_assert.svh
// Assertion macros used by the checker file of the key scan to MIDI block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef KEY_SCAN_TO_MIDI_EVENTS_ASSERT_SVH
`define KEY_SCAN_TO_MIDI_EVENTS_ASSERT_SVH

// Same-cycle implication, switched off while reset is held.
`define KSTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kstm check failed");

// Next-cycle implication, switched off while reset is held.
`define KSTM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kstm check failed");

// Next-cycle implication that also holds across reset.
`define KSTM_ASSERT_NXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("kstm check failed");

`endif

FILE: hw/rtl/kstm_pkg.sv
// Types and constants of the key scan to MIDI event block.
// Used by the front end, the event queue and the byte sender.
package kstm_pkg;

  // Scan frame layout.
  localparam int unsigned POS_W     = 7;
  localparam int unsigned KEY_SLOTS = 63;      // stored key bits, positions 1 to 63
  localparam logic [POS_W-1:0] FIRST_POS  = 7'd1;
  localparam logic [POS_W-1:0] LOW_LAST   = 7'd31;
  localparam logic [POS_W-1:0] HIGH_FIRST = 7'd34;
  localparam logic [POS_W-1:0] PEDAL_POS  = 7'd64;

  // Note numbers: low half is 98 - 2*pos, high half is 101 - 2*(pos - 31),
  // which is 163 - 2*pos. Transpose is added on top, modulo 256.
  localparam logic [7:0] LOW_BASE  = 8'd98;
  localparam logic [7:0] HIGH_BASE = 8'd163;

  // MIDI status and data bytes.
  localparam logic [7:0] NOTE_ON      = 8'h90;
  localparam logic [7:0] NOTE_OFF     = 8'h80;
  localparam logic [7:0] CTRL_CHANGE  = 8'hB0;
  localparam logic [7:0] SUSTAIN_CTRL = 8'd64;
  localparam logic [7:0] VEL_ON       = 8'd64;
  localparam logic [7:0] VEL_OFF      = 8'd0;
  localparam logic [7:0] CTRL_ON      = 8'd127;
  localparam logic [7:0] CTRL_OFF     = 8'd0;

  // Byte index within one message.
  localparam logic [1:0] BYTE_STATUS = 2'd0;
  localparam logic [1:0] BYTE_DATA1  = 2'd1;
  localparam logic [1:0] BYTE_DATA2  = 2'd2;

  // One complete three-byte message waiting to be sent.
  typedef struct packed {
    logic [7:0] status;
    logic [7:0] data1;
    logic [7:0] data2;
  } event_t;

endpackage

FILE: hw/rtl/key_scan_to_midi_events.sv
// Channel  Signals                          Contents
// scan in  s_tvalid s_tready s_tdata s_tuser  data_bit, pedal_level; sync_level
// midi out m_tvalid m_tready m_tdata m_tlast  midi_byte; last_byte
// config   cfg_valid cfg_ready cfg_data       transpose, always ready
//
// One scan edge is taken per cycle while the message queue has room.
// Each change of a note key or of the pedal yields a message of three bytes,
// sent one per cycle while m_tready is high, so the byte sender sets the rate.
// Reset is synchronous; key bits clear and the pedal reads high.
// An output stall fills the queue of QUEUE_DEPTH messages, then holds off scan edges.
//
// Top level of the key scan to MIDI event block; uses kstm_pkg,
// kstm_front, kstm_queue and kstm_back.
module key_scan_to_midi_events import kstm_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  // Configuration
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data,     // transpose
  // Scan edges
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,      // [0] data_bit, [1] pedal_level, [7:2] zero
  input  logic       s_tuser,      // [0] sync_level
  // MIDI bytes
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,      // [7:0] midi_byte
  output logic       m_tlast       // last_byte
);

  event_t push_event;
  event_t pop_event;
  logic   q_push;
  logic   q_pop;
  logic   q_full;
  logic   q_empty;

  // The transpose register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  kstm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .data_bit    (s_tdata[0]),
    .pedal_level (s_tdata[1]),
    .sync_level  (s_tuser),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_event     (push_event)
  );

  kstm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_event),
    .pop       (q_pop),
    .pop_data  (pop_event),
    .full      (q_full),
    .empty     (q_empty)
  );

  kstm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_event   (pop_event),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .midi_byte (m_tdata),
    .last_byte (m_tlast)
  );

endmodule

FILE: hw/rtl/kstm_front.sv
// Front end: accepts scan edges, tracks the frame position and the stored
// key and pedal state, and turns changes into MIDI messages. Uses kstm_pkg.
module kstm_front import kstm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // Configuration write channel
  input  logic       cfg_valid,
  input  logic [4:0] cfg_data,
  // Scan edge request
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       data_bit,
  input  logic       pedal_level,
  input  logic       sync_level,
  // Event queue side
  input  logic       q_full,
  output logic       q_push,
  output event_t     q_event
);

  logic [4:0]           transpose;
  logic [POS_W-1:0]     scan_position;
  logic [POS_W-1:0]     scan_position_next;
  logic [KEY_SLOTS-1:0] key_ring;
  logic                 pedal_previous;

  logic             accept;
  logic             drop;
  logic [POS_W-1:0] pos;
  logic             is_key_pos;
  logic             is_pedal_pos;
  logic             key_changed;
  logic             note_pos;
  logic [7:0]       note_base;
  logic [7:0]       note;

  // An edge is taken whenever the queue has room for what it may produce.
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // While waiting for sync, a sync edge is dropped and any other edge is slot one.
  assign drop         = (scan_position == '0) && sync_level;
  assign pos          = (scan_position == '0) ? FIRST_POS : scan_position;
  assign is_key_pos   = (pos != PEDAL_POS);
  assign is_pedal_pos = (pos == PEDAL_POS);

  // The ring holds the bits of positions 1 to 63; the head is always the current slot.
  assign key_changed = key_ring[0] != data_bit;
  assign note_pos    = (pos <= LOW_LAST) || (pos >= HIGH_FIRST);

  // Note number, computed modulo 256.
  assign note_base = (pos <= LOW_LAST) ? LOW_BASE : HIGH_BASE;
  assign note      = 8'({3'b000, transpose} + note_base - {pos, 1'b0});

  assign scan_position_next = is_pedal_pos ? '0 : POS_W'(pos + 1'b1);

  // Message build and queue request.
  always_comb begin
    q_push  = 1'b0;
    q_event = '{status: CTRL_CHANGE, data1: SUSTAIN_CTRL, data2: CTRL_OFF};
    if (is_key_pos) begin
      q_push = accept && !drop && key_changed && note_pos;
      if (data_bit) begin
        q_event = '{status: NOTE_ON, data1: note, data2: VEL_ON};
      end else begin
        q_event = '{status: NOTE_OFF, data1: note, data2: VEL_OFF};
      end
    end else begin
      q_push = accept && !drop && (pedal_level != pedal_previous);
      if (pedal_level) begin
        q_event.data2 = CTRL_ON;
      end
    end
  end

  // Transpose register.
  always_ff @(posedge clk) begin
    if (rst) begin
      transpose <= '0;
    end else if (cfg_valid) begin
      transpose <= cfg_data;
    end
  end

  // Frame position, key ring and pedal state.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_position  <= '0;
      key_ring       <= '0;
      pedal_previous <= 1'b1;
    end else if (accept && !drop) begin
      scan_position <= scan_position_next;
      if (is_key_pos) begin
        key_ring <= {data_bit, key_ring[KEY_SLOTS-1:1]};
      end else begin
        pedal_previous <= pedal_level;
      end
    end
  end

endmodule

FILE: hw/rtl/kstm_queue.sv
// Short message queue between the front end and the byte sender.
// Uses kstm_pkg for the message type.
module kstm_queue import kstm_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  event_t push_data,
  input  logic   pop,
  output event_t pop_data,
  output logic   full,
  output logic   empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  event_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  // Slot storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

endmodule

FILE: hw/rtl/kstm_back.sv
// Byte sender: takes messages from the queue and sends their three bytes
// in order on the output stream. Uses kstm_pkg.
module kstm_back import kstm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // Event queue side
  input  logic       q_empty,
  input  event_t     q_event,
  output logic       q_pop,
  // Byte stream request
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] midi_byte,
  output logic       last_byte
);

  event_t     cur;
  logic       busy;
  logic [1:0] byte_idx;
  logic       take;

  // A new message loads when idle or as the last byte leaves.
  assign take  = !busy || (out_ready && byte_idx == BYTE_DATA2);
  assign q_pop = take && !q_empty;

  assign out_valid = busy;
  assign last_byte = (byte_idx == BYTE_DATA2);

  // Byte select.
  always_comb begin
    case (byte_idx)
      BYTE_STATUS: midi_byte = cur.status;
      BYTE_DATA1:  midi_byte = cur.data1;
      BYTE_DATA2:  midi_byte = cur.data2;
      default:     midi_byte = cur.status;
    endcase
  end

  // Held message.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_event;
    end
  end

  // Send state.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      byte_idx <= BYTE_STATUS;
    end else if (take) begin
      busy     <= !q_empty;
      byte_idx <= BYTE_STATUS;
    end else if (out_ready) begin
      byte_idx <= 2'(byte_idx + 1'b1);
    end
  end

endmodule

FILE: hw/rtl/kstm_checker.sv
// Port-level checks of the key scan to MIDI block, bound to its top level.
// Depends on the assertion macros in key_scan_to_midi_events_assert.svh.
`include "key_scan_to_midi_events_assert.svh"

module kstm_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  logic [1:0] phase;

  // Byte position within the current message, as seen on the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (m_tvalid && m_tready) begin
      phase <= m_tlast ? 2'd0 : 2'(phase + 1'b1);
    end
  end

  // A stalled byte holds.
  `KSTM_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

  // Messages open with a status byte and carry data bytes after it.
  `KSTM_ASSERT_IMP(a_status, m_tvalid && phase == 2'd0, m_tdata[7])
  `KSTM_ASSERT_IMP(a_data, m_tvalid && phase != 2'd0, !m_tdata[7])

  // Every message is exactly three bytes long.
  `KSTM_ASSERT_IMP(a_length, m_tvalid, m_tlast == (phase == 2'd2))

  // Nothing is offered right after reset.
  `KSTM_ASSERT_NXT_ALWAYS(a_reset, rst, !m_tvalid)

endmodule

bind key_scan_to_midi_events kstm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
